// ===== hdl/alfl_pkg.sv =====
// Package for the array linked list with free list.
// Holds payload widths, status and operation codes, FSM states and shared structs.
// No dependencies.
package alfl_pkg;

  // Default pool size; the top level can override it
  localparam int POOL_NODES_DEF = 128;

  // Fixed field widths
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 7;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_REMOVE = 1'b1
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_INSERTED  = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_REMOVED   = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_INS,
    S_REM_CMP,
    S_REM_FREE
  } state_t;

  typedef struct packed {
    kind_t                     kind;
    logic signed [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot;
  } res_t;

endpackage

// ===== hdl/alfl_if.sv =====
// Channel interfaces for the array linked list block.
// Depends on alfl_pkg for the field widths.
interface alfl_in_if;
  import alfl_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

interface alfl_out_if;
  import alfl_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;

  modport source (output valid, output status, output slot, input ready);
  modport sink   (input valid, input status, input slot, output ready);
endinterface

// ===== hdl/alfl_ram.sv =====
// Simple dual-port synchronous RAM: one write port, one read port, registered read.
// No dependencies.
module alfl_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/alfl_ctrl.sv =====
// List controller: init sweep, insert and remove sequencing over the node stores.
// Depends on alfl_pkg and alfl_ram (value store and link store).
module alfl_ctrl #(
  parameter int POOL_NODES = alfl_pkg::POOL_NODES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          req_go,
  input  alfl_pkg::req_t req,
  output logic          idle,
  output logic          res_valid,
  output alfl_pkg::res_t res
);
  import alfl_pkg::*;

  localparam int IdxW  = $clog2(POOL_NODES);
  localparam int LinkW = $clog2(POOL_NODES + 1);
  localparam logic [LinkW-1:0] NullLink = LinkW'(POOL_NODES);
  localparam logic [IdxW-1:0]  LastIdx  = IdxW'(POOL_NODES - 1);

  state_t                    state_r, state_nxt;
  logic [LinkW-1:0]          list_head_r, list_head_nxt;
  logic [LinkW-1:0]          free_head_r, free_head_nxt;
  logic [LinkW-1:0]          prev_r, prev_nxt;
  logic [IdxW-1:0]           cur_r, cur_nxt;
  logic [IdxW-1:0]           init_idx_r, init_idx_nxt;
  logic signed [VALUE_W-1:0] val_r, val_nxt;

  logic                      link_we;
  logic [IdxW-1:0]           link_waddr;
  logic [LinkW-1:0]          link_wdata;
  logic [LinkW-1:0]          link_rdata;
  logic                      value_we;
  logic [IdxW-1:0]           value_waddr;
  logic [VALUE_W-1:0]        value_rdata;
  logic [IdxW-1:0]           rd_addr;

  function automatic logic is_node(input logic [LinkW-1:0] link);
    return link < NullLink;
  endfunction

  function automatic logic [SLOT_W-1:0] to_slot(input logic [IdxW-1:0] idx);
    logic [SLOT_W+IdxW-1:0] wide;
    wide = {{SLOT_W{1'b0}}, idx};
    return wide[SLOT_W-1:0];
  endfunction

  // Node stores
  alfl_ram #(.DEPTH(POOL_NODES), .WIDTH(VALUE_W)) u_value_ram (
    .clk     (clk),
    .wr_en   (value_we),
    .wr_addr (value_waddr),
    .wr_data (val_r),
    .rd_addr (rd_addr),
    .rd_data (value_rdata)
  );

  alfl_ram #(.DEPTH(POOL_NODES), .WIDTH(LinkW)) u_link_ram (
    .clk     (clk),
    .wr_en   (link_we),
    .wr_addr (link_waddr),
    .wr_data (link_wdata),
    .rd_addr (rd_addr),
    .rd_data (link_rdata)
  );

  // State and list pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      list_head_r <= NullLink;
      free_head_r <= '0;
      init_idx_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      list_head_r <= list_head_nxt;
      free_head_r <= free_head_nxt;
      init_idx_r  <= init_idx_nxt;
    end
  end

  // Walk position and search value
  always_ff @(posedge clk) begin
    prev_r <= prev_nxt;
    cur_r  <= cur_nxt;
    val_r  <= val_nxt;
  end

  // Next state, store accesses and results
  always_comb begin
    state_nxt     = state_r;
    list_head_nxt = list_head_r;
    free_head_nxt = free_head_r;
    init_idx_nxt  = init_idx_r;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    val_nxt       = val_r;
    link_we       = 1'b0;
    link_waddr    = cur_r;
    link_wdata    = free_head_r;
    value_we      = 1'b0;
    value_waddr   = free_head_r[IdxW-1:0];
    rd_addr       = '0;
    idle          = 1'b0;
    res_valid     = 1'b0;
    res.status    = STAT_NOT_FOUND;
    res.slot      = '0;

    case (state_r)
      // Chain every node into the free list, one entry per cycle
      S_INIT: begin
        link_we      = 1'b1;
        link_waddr   = init_idx_r;
        link_wdata   = LinkW'(init_idx_r) + LinkW'(1);
        init_idx_nxt = init_idx_r + IdxW'(1);
        if (init_idx_r == LastIdx) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        idle = 1'b1;
        if (req_go) begin
          val_nxt = req.value;
          if (req.kind == KIND_INSERT) begin
            if (!is_node(free_head_r)) begin
              res_valid  = 1'b1;
              res.status = STAT_FULL;
            end else begin
              // Fetch the link of the first free node
              rd_addr   = free_head_r[IdxW-1:0];
              state_nxt = S_INS;
            end
          end else begin
            if (!is_node(list_head_r)) begin
              res_valid  = 1'b1;
              res.status = STAT_NOT_FOUND;
            end else begin
              // Start the walk at the head
              rd_addr   = list_head_r[IdxW-1:0];
              cur_nxt   = list_head_r[IdxW-1:0];
              prev_nxt  = NullLink;
              state_nxt = S_REM_CMP;
            end
          end
        end
      end

      // Store the value, link the node at the head, advance the free list
      S_INS: begin
        value_we      = 1'b1;
        link_we       = 1'b1;
        link_waddr    = free_head_r[IdxW-1:0];
        link_wdata    = list_head_r;
        free_head_nxt = link_rdata;
        list_head_nxt = free_head_r;
        res_valid     = 1'b1;
        res.status    = STAT_INSERTED;
        res.slot      = to_slot(free_head_r[IdxW-1:0]);
        state_nxt     = S_IDLE;
      end

      // Compare the current node; unlink it on a match, else step on or, at the list end, answer not found
      S_REM_CMP: begin
        if (value_rdata == val_r) begin
          if (is_node(prev_r)) begin
            link_we    = 1'b1;
            link_waddr = prev_r[IdxW-1:0];
            link_wdata = link_rdata;
          end else begin
            list_head_nxt = link_rdata;
          end
          state_nxt = S_REM_FREE;
        end else if (is_node(link_rdata)) begin
          rd_addr  = link_rdata[IdxW-1:0];
          prev_nxt = LinkW'(cur_r);
          cur_nxt  = link_rdata[IdxW-1:0];
        end else begin
          res_valid  = 1'b1;
          res.status = STAT_NOT_FOUND;
          state_nxt  = S_IDLE;
        end
      end

      // Push the freed node on the free list
      S_REM_FREE: begin
        link_we       = 1'b1;
        link_waddr    = cur_r;
        link_wdata    = free_head_r;
        free_head_nxt = LinkW'(cur_r);
        res_valid     = 1'b1;
        res.status    = STAT_REMOVED;
        res.slot      = to_slot(cur_r);
        state_nxt     = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/array_linked_list_with_free_list_top.sv =====
// Top level of the array linked list with free list.
// Depends on alfl_pkg, alfl_if and alfl_ctrl.
//
// A pool of POOL_NODES nodes (2 to 128) in two RAMs with registered read holds a
// singly linked list of signed 32-bit values and a free list. After reset the
// block sweeps the link store to chain all nodes into the free list; in_ch.ready
// stays low during the sweep. Each beat yields exactly one result beat. An
// insert reads the free link, then writes back; an insert into a full pool or a
// remove from an empty list answers in the accept cycle. A remove visits one list
// node per cycle through the read port of the value and link stores. One item is
// in work at a time; a two-deep result buffer lets the next beat be accepted
// while one result still waits on out_ch.
module array_linked_list_with_free_list_top #(
  parameter int POOL_NODES = alfl_pkg::POOL_NODES_DEF
) (
  input logic        clk,
  input logic        rst_n,
  alfl_in_if.sink    in_ch,
  alfl_out_if.source out_ch
);
  import alfl_pkg::*;

  logic req_go;
  logic idle;
  req_t req;
  logic res_valid;
  res_t res;

  logic out_vld_r, out_vld_nxt;
  logic skd_vld_r, skd_vld_nxt;
  res_t out_res_r, out_res_nxt;
  res_t skd_res_r, skd_res_nxt;
  logic pop;

  // Accept a beat when idle and the result buffer has room
  assign in_ch.ready = idle && !skd_vld_r;
  assign req_go      = in_ch.valid && in_ch.ready;
  assign req.kind    = kind_t'(in_ch.kind);
  assign req.value   = in_ch.value;

  alfl_ctrl #(.POOL_NODES(POOL_NODES)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_go    (req_go),
    .req       (req),
    .idle      (idle),
    .res_valid (res_valid),
    .res       (res)
  );

  // Two-deep result buffer: output register plus skid entry
  assign pop = out_vld_r && out_ch.ready;

  always_comb begin
    out_vld_nxt = out_vld_r;
    out_res_nxt = out_res_r;
    skd_vld_nxt = skd_vld_r;
    skd_res_nxt = skd_res_r;
    if (pop || !out_vld_r) begin
      if (skd_vld_r) begin
        out_vld_nxt = 1'b1;
        out_res_nxt = skd_res_r;
        skd_vld_nxt = res_valid;
        skd_res_nxt = res;
      end else begin
        out_vld_nxt = res_valid;
        out_res_nxt = res;
      end
    end else if (res_valid) begin
      skd_vld_nxt = 1'b1;
      skd_res_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      skd_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
      skd_vld_r <= skd_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
    skd_res_r <= skd_res_nxt;
  end

  assign out_ch.valid  = out_vld_r;
  assign out_ch.status = out_res_r.status;
  assign out_ch.slot   = out_res_r.slot;

endmodule

// ===== hdl/alfl_checker.sv =====
// Port-level checker for the array linked list top, with its bind statement.
// Depends on alfl_pkg; attaches to array_linked_list_with_free_list_top.
module alfl_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [alfl_pkg::STATUS_W-1:0] out_status,
  input logic [alfl_pkg::SLOT_W-1:0]   out_slot
);
  import alfl_pkg::*;

  // Reset empties the result buffer
  a_reset_out_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat shown right after reset");

  // The init sweep follows reset, so no beat is taken then
  a_reset_sweep: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input ready during init sweep");

  // Full and not-found results carry slot zero
  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_FULL || out_status == STAT_NOT_FOUND)
      |-> out_slot == '0)
    else $error("nonzero slot on full or not-found result");

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_slot))
    else $error("result beat changed while stalled");

endmodule

bind array_linked_list_with_free_list_top alfl_checker u_alfl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_slot   (out_ch.slot)
);

// ===== tb/tb.sv =====
// Testbench for the array linked list with free list.
// Depends on alfl_pkg, alfl_if and array_linked_list_with_free_list_top.
// Drives insert/remove beats against a behavioral pool model and checks each result beat.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import alfl_pkg::*;

  localparam int NODES        = POOL_NODES_DEF;
  localparam int RANDOM_ITEMS = 1330;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int LONG_HOLD    = 400;

  typedef enum logic [1:0] {
    MODE_FILL,
    MODE_DRAIN,
    MODE_MIX
  } phase_mode_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_EVERY4,
    RX_MOSTLY
  } rx_mode_t;

  typedef struct packed {
    kind_t             kind;
    logic [31:0]       value;
    bit                typed;
    status_t           status;
    logic [SLOT_W-1:0] slot;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;

  alfl_in_if  in_ch ();
  alfl_out_if out_ch ();

  array_linked_list_with_free_list_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Pool model state
  logic signed [31:0] node_value [NODES];
  int                 node_link  [NODES];
  int                 list_first;
  int                 free_first;

  res_t expected_replies [$];
  int   error_count = 0;
  int   cycle_count = 0;
  int   reply_count = 0;
  bit   long_hold_go = 1'b0;
  int   burst_left = 1;
  bit   gaps_on = 1'b1;

  // Directed rows: empty list, extremes, duplicates, head/middle/tail unlink
  row_t directed_rows [20] = '{
    '{KIND_REMOVE, 32'h0000_0000, 1'b1, STAT_NOT_FOUND, 7'd0},
    '{KIND_INSERT, 32'h8000_0000, 1'b1, STAT_INSERTED,  7'd0},
    '{KIND_INSERT, 32'h7FFF_FFFF, 1'b1, STAT_INSERTED,  7'd1},
    '{KIND_INSERT, 32'hFFFF_FFFF, 1'b1, STAT_INSERTED,  7'd2},
    '{KIND_INSERT, 32'h0000_0000, 1'b1, STAT_INSERTED,  7'd3},
    '{KIND_INSERT, 32'h7FFF_FFFF, 1'b1, STAT_INSERTED,  7'd4},
    '{KIND_REMOVE, 32'h7FFF_FFFF, 1'b1, STAT_REMOVED,   7'd4},
    '{KIND_REMOVE, 32'h7FFF_FFFF, 1'b1, STAT_REMOVED,   7'd1},
    '{KIND_REMOVE, 32'h7FFF_FFFF, 1'b1, STAT_NOT_FOUND, 7'd0},
    '{KIND_REMOVE, 32'h8000_0000, 1'b1, STAT_REMOVED,   7'd0},
    '{KIND_INSERT, 32'h1234_5678, 1'b0, STAT_INSERTED,  7'd0},
    '{KIND_REMOVE, 32'h0000_0000, 1'b0, STAT_INSERTED,  7'd0},
    '{KIND_REMOVE, 32'h0000_0001, 1'b0, STAT_INSERTED,  7'd0},
    '{KIND_INSERT, 32'h5555_5555, 1'b0, STAT_INSERTED,  7'd0},
    '{KIND_INSERT, 32'hAAAA_AAAA, 1'b0, STAT_INSERTED,  7'd0},
    '{KIND_REMOVE, 32'hFFFF_FFFF, 1'b0, STAT_INSERTED,  7'd0},
    '{KIND_REMOVE, 32'h5555_5555, 1'b0, STAT_INSERTED,  7'd0},
    '{KIND_REMOVE, 32'h1234_5678, 1'b0, STAT_INSERTED,  7'd0},
    '{KIND_REMOVE, 32'hAAAA_AAAA, 1'b0, STAT_INSERTED,  7'd0},
    '{KIND_REMOVE, 32'hAAAA_AAAA, 1'b0, STAT_INSERTED,  7'd0}
  };

  // Clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Chain every node into the free list, empty list
  task automatic clear_pool_model();
    for (int i = 0; i < NODES; i++) begin
      node_value[i] = '0;
      node_link[i]  = i + 1;
    end
    list_first = NODES;
    free_first = 0;
  endtask

  // Apply one operation to the pool model and return its result beat
  function automatic res_t apply_list_op(kind_t op, logic signed [31:0] v);
    res_t r;
    int   n;
    int   cur;
    int   prev;
    int   steps;
    bit   found;
    r.status = STAT_NOT_FOUND;
    r.slot   = '0;
    if (op == KIND_INSERT) begin
      if (free_first >= NODES) begin
        r.status = STAT_FULL;
      end else begin
        n             = free_first;
        free_first    = node_link[n];
        node_value[n] = v;
        node_link[n]  = list_first;
        list_first    = n;
        r.status      = STAT_INSERTED;
        r.slot        = n[SLOT_W-1:0];
      end
    end else begin
      prev  = NODES;
      cur   = list_first;
      steps = 0;
      found = 1'b0;
      // Walk from the head; unlink the first match and push it on the free list
      while (cur < NODES && steps < NODES && !found) begin
        if (node_value[cur] == v) begin
          if (prev < NODES) node_link[prev] = node_link[cur];
          else list_first = node_link[cur];
          node_link[cur] = free_first;
          free_first     = cur;
          r.status       = STAT_REMOVED;
          r.slot         = cur[SLOT_W-1:0];
          found          = 1'b1;
        end else begin
          prev = cur;
          cur  = node_link[cur];
          steps++;
        end
      end
    end
    return r;
  endfunction

  // Pick the value of a random node on the list, or a random word if empty
  function automatic logic signed [31:0] pick_listed_value();
    int cur;
    int count;
    int pick;
    count = 0;
    cur   = list_first;
    while (cur < NODES && count < NODES) begin
      count++;
      cur = node_link[cur];
    end
    if (count == 0) return $urandom;
    pick = $urandom_range(0, count - 1);
    cur  = list_first;
    repeat (pick) cur = node_link[cur];
    return node_value[cur];
  endfunction

  // Insert values: many duplicates, some extremes, mostly full random words
  function automatic logic signed [31:0] pick_insert_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 3) return $signed($urandom_range(0, 7)) - 32'sd3;
    if (sel == 3) begin
      case ($urandom_range(0, 3))
        0:       return 32'sh8000_0000;
        1:       return 32'sh7FFF_FFFF;
        2:       return -32'sd1;
        default: return 32'sd0;
      endcase
    end
    return $urandom;
  endfunction

  task automatic flag_mismatch(string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    error_count++;
  endtask

  // Offer one beat; predict it at the edge where it is taken
  task automatic offer_beat(kind_t k, logic signed [31:0] v, bit typed, res_t typed_res);
    bit   fire;
    res_t predicted;
    in_ch.valid <= 1'b1;
    in_ch.kind  <= k;
    in_ch.value <= v;
    do begin
      @(negedge clk);
      fire = in_ch.valid && in_ch.ready;
      if (fire) begin
        predicted = apply_list_op(k, v);
        expected_replies.push_back(typed ? typed_res : predicted);
      end
      @(posedge clk);
    end while (!fire);
    // Close the burst and, when gaps are on, idle for a random gap
    burst_left--;
    if (burst_left <= 0) begin
      if (gaps_on) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 20 : 5)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
  endtask

  // Hold the sender until every expected beat has come back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
  endtask

  // Receiver: long hold-off on request, otherwise a changing stall pattern
  initial begin
    int       hold_left;
    int       mode_left;
    int       tick;
    rx_mode_t rx_mode;
    logic     rdy;
    hold_left = 0;
    mode_left = 0;
    tick      = 0;
    rx_mode   = RX_OPEN;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (long_hold_go) begin
        long_hold_go = 1'b0;
        hold_left    = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(40, 160);
        end
        mode_left--;
        case (rx_mode)
          RX_OPEN:   rdy = 1'b1;
          RX_COIN:   rdy = 1'($urandom_range(0, 1));
          RX_EVERY4: rdy = (tick % 4 == 0);
          default:   rdy = ($urandom_range(0, 9) != 0);
        endcase
      end
      out_ch.ready <= rdy;
    end
  end

  // Result checker: sample at the falling edge, compare at the taking edge
  initial begin
    bit                hit;
    logic [1:0]        got_status;
    logic [SLOT_W-1:0] got_slot;
    res_t              want;
    forever begin
      @(negedge clk);
      hit        = (out_ch.valid === 1'b1) && (out_ch.ready === 1'b1);
      got_status = out_ch.status;
      got_slot   = out_ch.slot;
      @(posedge clk);
      if (hit) begin
        reply_count++;
        if (expected_replies.size() == 0) begin
          flag_mismatch($sformatf("beat %0d: result with nothing expected (status %0d slot %0d)",
                                  reply_count, got_status, got_slot));
        end else begin
          want = expected_replies.pop_front();
          if (got_status !== want.status)
            flag_mismatch($sformatf("beat %0d: status %0d, expected %0d",
                                    reply_count, got_status, want.status));
          if (got_slot !== want.slot)
            flag_mismatch($sformatf("beat %0d: slot %0d, expected %0d",
                                    reply_count, got_slot, want.slot));
        end
      end
    end
  end

  // Timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Stimulus
  initial begin
    phase_mode_t mode;
    int          phase;
    int          random_sent;
    int          phase_len;
    int          insert_pct;
    kind_t       op;
    logic signed [31:0] v;
    res_t        typed_res;

    rst_n       = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.kind  = KIND_INSERT;
    in_ch.value = '0;
    clear_pool_model();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    foreach (directed_rows[i]) begin
      typed_res.status = directed_rows[i].status;
      typed_res.slot   = directed_rows[i].slot;
      offer_beat(directed_rows[i].kind, directed_rows[i].value, directed_rows[i].typed,
                 typed_res);
    end
    wait_drained();

    // Random phases: fill past full, drain past empty, mixed traffic
    random_sent = 0;
    phase       = 0;
    while (random_sent < RANDOM_ITEMS) begin
      mode      = phase_mode_t'(phase % 3);
      phase_len = (mode == MODE_FILL) ? $urandom_range(180, 260) : $urandom_range(60, 200);
      // Trim the last phase to the item budget
      if (phase_len > RANDOM_ITEMS - random_sent) phase_len = RANDOM_ITEMS - random_sent;
      gaps_on   = ($urandom_range(0, 3) != 0);
      case (mode)
        MODE_FILL:  insert_pct = 90;
        MODE_DRAIN: insert_pct = 15;
        default:    insert_pct = 50;
      endcase
      // Stall the receiver while the sender keeps offering back to back
      if (phase == 1) begin
        long_hold_go = 1'b1;
        gaps_on      = 1'b0;
      end
      repeat (phase_len) begin
        if ($urandom_range(0, 99) < insert_pct) begin
          op = KIND_INSERT;
          v  = pick_insert_value();
        end else begin
          op = KIND_REMOVE;
          v  = ($urandom_range(0, 9) < 7) ? pick_listed_value() : pick_insert_value();
        end
        typed_res = '0;
        offer_beat(op, v, 1'b0, typed_res);
        random_sent++;
      end
      if (phase % 2 == 1) wait_drained();
      phase++;
    end

    // Settle and conclude
    wait_drained();
    repeat (NODES + 10) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/alfl_pkg.sv
hdl/alfl_if.sv
hdl/alfl_ram.sv
hdl/alfl_ctrl.sv
hdl/array_linked_list_with_free_list_top.sv
hdl/alfl_checker.sv
tb/tb.sv
